/* hw/rtl/fbs_pkg.sv */
package fbs_pkg;

  // Slot codes of the bracket, also used as the base_slot result field.
  localparam logic [1:0] SLOT_HIGH = 2'd0;
  localparam logic [1:0] SLOT_BEST = 2'd1;
  localparam logic [1:0] SLOT_LOW  = 2'd2;

  localparam int unsigned NumSlots  = 3;
  localparam int unsigned SlotWidth = 2;

  typedef logic [SlotWidth-1:0] slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FIB,
    ST_EMIT
  } fbs_state_e;

endpackage

/* hw/rtl/fbs_if.sv */
interface fbs_cand_if #(
  parameter int unsigned COUNT_WIDTH   = 20,
  parameter int unsigned ENTROPY_WIDTH = 48
);
  logic                     valid;
  logic                     ready;
  logic [COUNT_WIDTH-1:0]   block_count;
  logic [ENTROPY_WIDTH-1:0] entropy;

  modport source (output valid, output block_count, output entropy, input ready);
  modport sink   (input valid, input block_count, input entropy, output ready);
endinterface

interface fbs_res_if #(
  parameter int unsigned COUNT_WIDTH = 20
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             base_slot;
  logic [COUNT_WIDTH-1:0] base_blocks;
  logic [COUNT_WIDTH-1:0] merge_count;
  logic                   search_done;

  modport source (output valid, output base_slot, output base_blocks,
                  output merge_count, output search_done, input ready);
  modport sink   (input valid, input base_slot, input base_blocks,
                  input merge_count, input search_done, output ready);
endinterface

/* hw/rtl/fbs_fib_unit.sv */
module fbs_fib_unit #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COUNT_WIDTH-1:0] gap_i,
  output logic                   done_o,
  output logic [COUNT_WIDTH-1:0] step_o
);

  logic                   busy_q;
  logic [COUNT_WIDTH-1:0] prev_q;
  logic [COUNT_WIDTH-1:0] cur_q;
  logic [COUNT_WIDTH-1:0] gap_q;
  logic [COUNT_WIDTH:0]   sum;
  logic                   fits;

  // One Fibonacci term per cycle: advance while the next term still fits in the gap.
  assign sum  = {1'b0, prev_q} + {1'b0, cur_q};
  assign fits = (sum <= {1'b0, gap_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && !fits) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prev_q <= COUNT_WIDTH'(1);
      cur_q  <= COUNT_WIDTH'(1);
      gap_q  <= gap_i;
    end else if (busy_q && fits) begin
      prev_q <= cur_q;
      cur_q  <= sum[COUNT_WIDTH-1:0];
    end
  end

  assign done_o = busy_q && !fits;
  assign step_o = prev_q;

endmodule

/* hw/rtl/fibonacci_bracket_search.sv */
// Path: the accepted beat files the candidate, then the DECIDE state chooses the base slot,
//   the FIB state runs the Fibonacci unit when a step is needed, and the EMIT state loads
//   the result register, waiting while an earlier result has not been taken.
// Throughput: one candidate at a time; the next beat is taken only once the result is
//   registered and the block is back in the idle state.
// Reset (async, active low) empties all slots, zeroes block counts and clears the done flag.
module fibonacci_bracket_search #(
  parameter int unsigned COUNT_WIDTH   = 20,
  parameter int unsigned ENTROPY_WIDTH = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbs_cand_if.sink   cand_i,
  fbs_res_if.source  res_o
);

  import fbs_pkg::*;

  // The bracket: high, best and low slots, plus the sticky done flag.
  fbs_state_e                state_q, state_d;
  logic [NumSlots-1:0]       valid_q;
  logic [COUNT_WIDTH-1:0]    blocks_q  [NumSlots];
  logic [ENTROPY_WIDTH-1:0]  entropy_q [NumSlots];
  logic                      found_q, found_d;

  logic                      accept;
  logic                      cand_le;
  logic                      best_gt;
  logic [NumSlots-1:0]       wr_cand;
  logic [NumSlots-1:0]       wr_best;

  // Decision datapath.
  logic signed [COUNT_WIDTH:0] d_hb, d_bl, d_hl, d_b1, gap_sel;
  slot_t                       base_d, base_q;
  logic                        skip_fib;
  logic                        gap_nonpos;
  logic                        fib_start;
  logic                        fib_done;
  logic [COUNT_WIDTH-1:0]      fib_step;
  logic [COUNT_WIDTH-1:0]      merge_q;

  // Result register, so a finished result can wait while the next candidate comes in.
  logic                        res_valid_q;
  slot_t                       res_slot_q;
  logic [COUNT_WIDTH-1:0]      res_blocks_q;
  logic [COUNT_WIDTH-1:0]      res_merge_q;
  logic                        res_done_q;
  logic                        res_load;

  assign cand_i.ready = (state_q == ST_IDLE);
  assign accept       = cand_i.valid && cand_i.ready;

  // Filing the candidate. An empty best slot takes it; when its entropy is not above the best,
  // the old best moves to the side given by its block count, else the candidate goes to its own.
  assign cand_le = (cand_i.entropy <= entropy_q[SLOT_BEST]);
  assign best_gt = (blocks_q[SLOT_BEST] > cand_i.block_count);

  always_comb begin
    wr_cand = '0;
    wr_best = '0;
    if (accept) begin
      if (!valid_q[SLOT_BEST]) begin
        wr_cand[SLOT_BEST] = 1'b1;
      end else if (cand_le) begin
        wr_cand[SLOT_BEST] = 1'b1;
        if (best_gt) begin
          wr_best[SLOT_HIGH] = 1'b1;
        end else begin
          wr_best[SLOT_LOW] = 1'b1;
        end
      end else if (best_gt) begin
        wr_cand[SLOT_LOW] = 1'b1;
      end else begin
        wr_cand[SLOT_HIGH] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        blocks_q[i]  <= '0;
        entropy_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumSlots; i++) begin
        if (wr_cand[i]) begin
          valid_q[i]   <= 1'b1;
          blocks_q[i]  <= cand_i.block_count;
          entropy_q[i] <= cand_i.entropy;
        end else if (wr_best[i]) begin
          valid_q[i]   <= 1'b1;
          blocks_q[i]  <= blocks_q[SLOT_BEST];
          entropy_q[i] <= entropy_q[SLOT_BEST];
        end
      end
    end
  end

  // Gaps between slots, one bit wider and signed so negative gaps are seen.
  // An empty high slot reads as a block count of zero, its reset value.
  assign d_hb = $signed({1'b0, blocks_q[SLOT_HIGH]}) - $signed({1'b0, blocks_q[SLOT_BEST]});
  assign d_bl = $signed({1'b0, blocks_q[SLOT_BEST]}) - $signed({1'b0, blocks_q[SLOT_LOW]});
  assign d_hl = $signed({1'b0, blocks_q[SLOT_HIGH]}) - $signed({1'b0, blocks_q[SLOT_LOW]});
  assign d_b1 = $signed({1'b0, blocks_q[SLOT_BEST]}) - $signed((COUNT_WIDTH+1)'(1));

  // Choosing the base slot. Without a low slot the search descends from the best
  // slot and finishes once the step shrinks to zero. With a low slot it finishes
  // when the bracket has closed; otherwise it steps into the wider interval, the high one on a tie.
  always_comb begin
    base_d   = SLOT_BEST;
    gap_sel  = d_b1;
    skip_fib = 1'b0;
    found_d  = found_q;
    if (!valid_q[SLOT_LOW]) begin
      found_d = found_q || d_b1[COUNT_WIDTH] || (d_b1 == '0);
    end else begin
      if ((valid_q[SLOT_HIGH] && (d_hl == (COUNT_WIDTH+1)'(2))) ||
          (!valid_q[SLOT_HIGH] && (d_bl == (COUNT_WIDTH+1)'(1)))) begin
        found_d = 1'b1;
      end
      if (found_d) begin
        skip_fib = 1'b1;
      end else if (!valid_q[SLOT_HIGH] && !d_bl[COUNT_WIDTH] && (d_bl != '0)) begin
        gap_sel = d_bl;
      end else if (d_hb >= d_bl) begin
        base_d  = SLOT_HIGH;
        gap_sel = d_hb;
      end else begin
        gap_sel = d_bl;
      end
    end
  end

  // A gap of zero or below has a step of zero, so the unit is not started.
  assign gap_nonpos = gap_sel[COUNT_WIDTH] || (gap_sel == '0);
  assign fib_start  = (state_q == ST_DECIDE) && !skip_fib && !gap_nonpos;

  fbs_fib_unit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fib (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fib_start),
    .gap_i   (gap_sel[COUNT_WIDTH-1:0]),
    .done_o  (fib_done),
    .step_o  (fib_step)
  );

  assign res_load = (state_q == ST_EMIT) && (!res_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = fib_start ? ST_FIB : ST_EMIT;
      end
      ST_FIB: begin
        if (fib_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (state_q == ST_DECIDE) begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      base_q  <= base_d;
      merge_q <= '0;
    end else if ((state_q == ST_FIB) && fib_done) begin
      merge_q <= fib_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_slot_q   <= base_q;
      res_blocks_q <= blocks_q[base_q];
      res_merge_q  <= merge_q;
      res_done_q   <= found_q;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.base_slot   = res_slot_q;
  assign res_o.base_blocks = res_blocks_q;
  assign res_o.merge_count = res_merge_q;
  assign res_o.search_done = res_done_q;

endmodule
